[sv/mbp_pkg.sv]
// Shared types, constants and register codes for the Mandelbrot escape-time pixel block.
package mbp_pkg;

    // Default iteration limit of the chain.
    localparam int unsigned MAX_ITERATIONS_DEF = 100;

    // Field and datapath widths.
    localparam int unsigned PIX_W     = 12;
    localparam int unsigned C_W       = 32;
    localparam int unsigned Z_W       = 36;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned FRAC_BITS = 29;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned COL_W     = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    // Escape limits: 2.0 in Q.29 for one component, 4.0 in Q.58 for the squared norm.
    localparam logic signed [Z_W-1:0]  Z_TWO    = 36'sd1073741824;
    localparam logic [PROD_W-1:0]      MAG_FOUR = 64'h1000_0000_0000_0000;

    // Saturation limits of the Q3.29 point.
    localparam logic signed [C_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [C_W-1:0] C_MIN = 32'sh8000_0000;

    // Default view after reset.
    localparam logic signed [C_W-1:0] REAL_MIN_RST  = -32'sd1073741824;
    localparam logic signed [C_W-1:0] IMAG_MIN_RST  = -32'sd456340275;
    localparam logic signed [C_W-1:0] STEP_REAL_RST = 32'sd838861;
    localparam logic signed [C_W-1:0] STEP_IMAG_RST = 32'sd838861;

    // Colour polynomial gains, already scaled by 255.
    localparam longint unsigned RED_GAIN   = 9 * 255;
    localparam longint unsigned GREEN_GAIN = 15 * 255;
    localparam longint unsigned BLUE_GAIN  = 17 * 255;

    // Configuration register codes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REAL_MIN  = 3'd0,
        REG_IMAG_MIN  = 3'd1,
        REG_STEP_REAL = 3'd2,
        REG_STEP_IMAG = 3'd3
    } cfg_reg_t;

    // One pixel as it travels down the chain of iteration cells.
    typedef struct packed {
        logic                   done;
        logic [CNT_W-1:0]       count;
        logic [COL_W-1:0]       red;
        logic [COL_W-1:0]       green;
        logic [COL_W-1:0]       blue;
        logic signed [Z_W-1:0]  zr;
        logic signed [Z_W-1:0]  zi;
        logic signed [C_W-1:0]  cr;
        logic signed [C_W-1:0]  ci;
    } item_t;

endpackage

[sv/mbp_map.sv]
// Configuration registers and the mapping of a pixel coordinate to its complex point.
module mbp_map (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mbp_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 accept,
    input  logic [mbp_pkg::PIX_W-1:0]            pixel_x,
    input  logic [mbp_pkg::PIX_W-1:0]            pixel_y,
    output logic                                 out_valid,
    output mbp_pkg::item_t                       out_item
);

    localparam int unsigned MUL_W = mbp_pkg::PIX_W + 1 + mbp_pkg::C_W;
    localparam int unsigned SUM_W = MUL_W + 1;

    logic signed [mbp_pkg::C_W-1:0] real_min_reg;
    logic signed [mbp_pkg::C_W-1:0] imag_min_reg;
    logic signed [mbp_pkg::C_W-1:0] step_real_reg;
    logic signed [mbp_pkg::C_W-1:0] step_imag_reg;

    logic                    mul_valid_reg;
    logic signed [MUL_W-1:0] prod_r_reg;
    logic signed [MUL_W-1:0] prod_i_reg;
    logic signed [MUL_W-1:0] prod_r_next;
    logic signed [MUL_W-1:0] prod_i_next;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_i;
    logic signed [mbp_pkg::C_W-1:0] cr_sat;
    logic signed [mbp_pkg::C_W-1:0] ci_sat;

    logic           out_valid_reg;
    mbp_pkg::item_t out_item_reg;
    mbp_pkg::item_t out_item_next;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_min_reg  <= mbp_pkg::REAL_MIN_RST;
            imag_min_reg  <= mbp_pkg::IMAG_MIN_RST;
            step_real_reg <= mbp_pkg::STEP_REAL_RST;
            step_imag_reg <= mbp_pkg::STEP_IMAG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbp_pkg::REG_REAL_MIN:  real_min_reg  <= cfg_data;
                mbp_pkg::REG_IMAG_MIN:  imag_min_reg  <= cfg_data;
                mbp_pkg::REG_STEP_REAL: step_real_reg <= cfg_data;
                mbp_pkg::REG_STEP_IMAG: step_imag_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // First stage: scale the coordinate by the step size.
    always_comb
    begin
        prod_r_next = MUL_W'($signed({1'b0, pixel_x})) * MUL_W'(step_real_reg);
        prod_i_next = MUL_W'($signed({1'b0, pixel_y})) * MUL_W'(step_imag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_i_reg <= prod_i_next;
    end

    // Second stage: add the origin and saturate to the Q3.29 range.
    always_comb
    begin
        sum_r = SUM_W'(real_min_reg) + SUM_W'(prod_r_reg);
        sum_i = SUM_W'(imag_min_reg) + SUM_W'(prod_i_reg);

        if (sum_r > SUM_W'(mbp_pkg::C_MAX))
            cr_sat = mbp_pkg::C_MAX;
        else if (sum_r < SUM_W'(mbp_pkg::C_MIN))
            cr_sat = mbp_pkg::C_MIN;
        else
            cr_sat = sum_r[mbp_pkg::C_W-1:0];

        if (sum_i > SUM_W'(mbp_pkg::C_MAX))
            ci_sat = mbp_pkg::C_MAX;
        else if (sum_i < SUM_W'(mbp_pkg::C_MIN))
            ci_sat = mbp_pkg::C_MIN;
        else
            ci_sat = sum_i[mbp_pkg::C_W-1:0];

        out_item_next       = '0;
        out_item_next.cr    = cr_sat;
        out_item_next.ci    = ci_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[sv/mbp_cell.sv]
// One iteration cell of the chain: squares z, tests for escape and forms z*z + c.
module mbp_cell #(
    parameter int unsigned IDX            = 0,
    parameter int unsigned MAX_ITERATIONS = mbp_pkg::MAX_ITERATIONS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  mbp_pkg::item_t in_item,
    output logic           out_valid,
    output mbp_pkg::item_t out_item
);

    // Colour of a pixel that escapes in this cell, fixed at elaboration.
    localparam longint unsigned N_VAL     = IDX;
    localparam longint unsigned K_VAL     = MAX_ITERATIONS - IDX;
    localparam longint unsigned M_VAL     = MAX_ITERATIONS;
    localparam longint unsigned M4        = M_VAL * M_VAL * M_VAL * M_VAL;
    localparam longint unsigned RED_RAW   =
        (mbp_pkg::RED_GAIN * K_VAL * N_VAL * N_VAL * N_VAL) / M4;
    localparam longint unsigned GREEN_RAW =
        (mbp_pkg::GREEN_GAIN * K_VAL * K_VAL * N_VAL * N_VAL) / M4;
    localparam longint unsigned BLUE_RAW  =
        (mbp_pkg::BLUE_GAIN * K_VAL * K_VAL * K_VAL * N_VAL) / (2 * M4);
    localparam logic [mbp_pkg::COL_W-1:0] RED   =
        (RED_RAW > 255) ? 8'd255 : mbp_pkg::COL_W'(RED_RAW);
    localparam logic [mbp_pkg::COL_W-1:0] GREEN =
        (GREEN_RAW > 255) ? 8'd255 : mbp_pkg::COL_W'(GREEN_RAW);
    localparam logic [mbp_pkg::COL_W-1:0] BLUE  =
        (BLUE_RAW > 255) ? 8'd255 : mbp_pkg::COL_W'(BLUE_RAW);
    localparam logic [mbp_pkg::CNT_W-1:0] CNT   = mbp_pkg::CNT_W'(IDX);

    logic                                abs_escape;
    logic signed [mbp_pkg::C_W-1:0]      zr_s;
    logic signed [mbp_pkg::C_W-1:0]      zi_s;
    logic signed [mbp_pkg::PROD_W-1:0]   rr_next;
    logic signed [mbp_pkg::PROD_W-1:0]   ii_next;
    logic signed [mbp_pkg::PROD_W-1:0]   ri_next;
    logic signed [mbp_pkg::PROD_W-1:0]   rr_reg;
    logic signed [mbp_pkg::PROD_W-1:0]   ii_reg;
    logic signed [mbp_pkg::PROD_W-1:0]   ri_reg;
    logic                                a_valid_reg;
    mbp_pkg::item_t                      a_item_reg;
    mbp_pkg::item_t                      a_item_next;

    logic [mbp_pkg::PROD_W-1:0]          mag;
    logic signed [mbp_pkg::PROD_W-1:0]   diff;
    logic signed [mbp_pkg::PROD_W-1:0]   diff_sh;
    logic signed [mbp_pkg::PROD_W-1:0]   ri_sh;
    logic                                out_valid_reg;
    mbp_pkg::item_t                      out_item_reg;
    mbp_pkg::item_t                      out_item_next;

    // Multiply stage: a component above 2 escapes before it is squared, so the
    // low 32 bits carry the whole value of any z that is multiplied.
    always_comb
    begin
        abs_escape = (in_item.zr > mbp_pkg::Z_TWO) || (in_item.zr < -mbp_pkg::Z_TWO) ||
                     (in_item.zi > mbp_pkg::Z_TWO) || (in_item.zi < -mbp_pkg::Z_TWO);
        zr_s    = in_item.zr[mbp_pkg::C_W-1:0];
        zi_s    = in_item.zi[mbp_pkg::C_W-1:0];
        // The operands are 32-bit values sign-extended to the product width.
        rr_next = mbp_pkg::PROD_W'(zr_s) * mbp_pkg::PROD_W'(zr_s);
        ii_next = mbp_pkg::PROD_W'(zi_s) * mbp_pkg::PROD_W'(zi_s);
        ri_next = mbp_pkg::PROD_W'(zr_s) * mbp_pkg::PROD_W'(zi_s);

        a_item_next = in_item;
        if (!in_item.done && abs_escape)
        begin
            a_item_next.done  = 1'b1;
            a_item_next.count = CNT;
            a_item_next.red   = RED;
            a_item_next.green = GREEN;
            a_item_next.blue  = BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= a_item_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        ri_reg     <= ri_next;
    end

    // Add stage: exact norm test against 4, then floor back to Q.29 and add c.
    // A z that goes on has norm at most 2, so the new value always fits.
    always_comb
    begin
        mag     = rr_reg + ii_reg;
        diff    = rr_reg - ii_reg;
        diff_sh = diff >>> mbp_pkg::FRAC_BITS;
        ri_sh   = ri_reg >>> (mbp_pkg::FRAC_BITS - 1);

        out_item_next    = a_item_reg;
        out_item_next.zr = $signed(diff_sh[mbp_pkg::Z_W-1:0]) +
                           {{(mbp_pkg::Z_W - mbp_pkg::C_W){a_item_reg.cr[mbp_pkg::C_W-1]}},
                            a_item_reg.cr};
        out_item_next.zi = $signed(ri_sh[mbp_pkg::Z_W-1:0]) +
                           {{(mbp_pkg::Z_W - mbp_pkg::C_W){a_item_reg.ci[mbp_pkg::C_W-1]}},
                            a_item_reg.ci};
        if (!a_item_reg.done && (mag > mbp_pkg::MAG_FOUR))
        begin
            out_item_next.done  = 1'b1;
            out_item_next.count = CNT;
            out_item_next.red   = RED;
            out_item_next.green = GREEN;
            out_item_next.blue  = BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[sv/mbp_tail.sv]
// Result stage: settles pixels that never escaped and drives the result ports.
module mbp_tail #(
    parameter int unsigned MAX_ITERATIONS = mbp_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  mbp_pkg::item_t                 in_item,
    output logic                           done,
    output logic [mbp_pkg::CNT_W-1:0]      iterations,
    output logic [mbp_pkg::COL_W-1:0]      red,
    output logic [mbp_pkg::COL_W-1:0]      green,
    output logic [mbp_pkg::COL_W-1:0]      blue
);

    localparam logic [mbp_pkg::CNT_W-1:0] CNT_MAX = mbp_pkg::CNT_W'(MAX_ITERATIONS);

    logic                          done_reg;
    logic [mbp_pkg::CNT_W-1:0]     iter_reg;
    logic [mbp_pkg::CNT_W-1:0]     iter_next;
    logic [mbp_pkg::COL_W-1:0]     red_reg;
    logic [mbp_pkg::COL_W-1:0]     red_next;
    logic [mbp_pkg::COL_W-1:0]     green_reg;
    logic [mbp_pkg::COL_W-1:0]     green_next;
    logic [mbp_pkg::COL_W-1:0]     blue_reg;
    logic [mbp_pkg::COL_W-1:0]     blue_next;

    // A pixel still bounded takes the full count; with t = 1 every polynomial is zero.
    always_comb
    begin
        if (in_item.done)
        begin
            iter_next  = in_item.count;
            red_next   = in_item.red;
            green_next = in_item.green;
            blue_next  = in_item.blue;
        end
        else
        begin
            iter_next  = CNT_MAX;
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg  <= iter_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done       = done_reg;
    assign iterations = iter_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

endmodule

[sv/mandelbrot_pixel_escape_color_top.sv]
// Top level of the Mandelbrot escape-time pixel colouring block.
//
// A request is one pixel (pixel_x, pixel_y), taken at a rising edge with start
// high and busy low. Busy stays low: the block takes a new request every cycle.
// The pixel is mapped to c = origin + index * step by a multiply stage and an
// add stage, then runs through a chain of MAX_ITERATIONS iteration cells, two
// register stages each (square, then norm test and update). The result leaves
// through one output register, and results come out in request order.
// Each result is shown for one cycle with done high; the receiver cannot stall.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods, when no request is in flight.
// Reset clears every valid flag in the chain, drops pending results and loads
// the default view into the four registers.
module mandelbrot_pixel_escape_color_top #(
    parameter int unsigned MAX_ITERATIONS = mbp_pkg::MAX_ITERATIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [mbp_pkg::PIX_W-1:0]         pixel_x,
    input  logic [mbp_pkg::PIX_W-1:0]         pixel_y,
    output logic                              done,
    output logic [mbp_pkg::CNT_W-1:0]         iterations,
    output logic [mbp_pkg::COL_W-1:0]         red,
    output logic [mbp_pkg::COL_W-1:0]         green,
    output logic [mbp_pkg::COL_W-1:0]         blue
);

    logic           accept;
    logic           link_valid [MAX_ITERATIONS+1];
    mbp_pkg::item_t link_item  [MAX_ITERATIONS+1];

    // The chain is fully pipelined, so a request is never held off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Coordinate mapping and configuration registers.
    mbp_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (link_valid[0]),
        .out_item  (link_item[0])
    );

    // Chain of iteration cells; cell g settles pixels that escape at step g.
    for (genvar g = 0; g < MAX_ITERATIONS; g++)
    begin : g_cell
        mbp_cell #(
            .IDX            (g),
            .MAX_ITERATIONS (MAX_ITERATIONS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[g]),
            .in_item   (link_item[g]),
            .out_valid (link_valid[g+1]),
            .out_item  (link_item[g+1])
        );
    end

    // Result register.
    mbp_tail #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_tail (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (link_valid[MAX_ITERATIONS]),
        .in_item    (link_item[MAX_ITERATIONS]),
        .done       (done),
        .iterations (iterations),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

[sv/mbp_checker.sv]
// Port-level checks of the Mandelbrot pixel block and the bind that attaches them.
module mbp_checker #(
    parameter int unsigned MAX_ITERATIONS = mbp_pkg::MAX_ITERATIONS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [mbp_pkg::CNT_W-1:0]         iterations,
    input logic [mbp_pkg::COL_W-1:0]         red,
    input logic [mbp_pkg::COL_W-1:0]         green,
    input logic [mbp_pkg::COL_W-1:0]         blue
);

    localparam int unsigned LATENCY = 2 * MAX_ITERATIONS + 3;
    localparam logic        NARROW  = (MAX_ITERATIONS <= 127);
    localparam logic [mbp_pkg::CNT_W-1:0] CNT_MAX = mbp_pkg::CNT_W'(MAX_ITERATIONS);

    // Every request is followed by a result with done high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
    else $error("request did not produce a result after the chain latency");

    // No result appears without a matching earlier request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

    // With a limit that fits the count field, the count never exceeds the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && NARROW) |-> (iterations <= CNT_MAX))
    else $error("iteration count above the limit");

    // At t = 0 and t = 1 all three colour polynomials vanish.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && NARROW && ((iterations == '0) || (iterations == CNT_MAX)))
        |-> ((red == '0) && (green == '0) && (blue == '0)))
    else $error("nonzero colour at an end of the palette");

endmodule

bind mandelbrot_pixel_escape_color_top mbp_checker #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
) u_mbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .iterations (iterations),
    .red        (red),
    .green      (green),
    .blue       (blue)
);
